### rtl/core/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Shared sizes, function codes and record types of the ARP cache with aging.
// ----------------------------------------------------------------------------
package arpc_pkg;

    // Table geometry.
    localparam int CACHE_SLOTS = 16;
    localparam int IDX_W       = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int CNT_W       = IDX_W + 1;

    // Field widths.
    localparam int FUNC_W = 2;
    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int AGE_W  = 8;

    // Reset value of the age limit register.
    localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 8'd15;

    // Function codes of an input transaction.
    localparam logic [FUNC_W-1:0] FUNC_LEARN  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // One stored table entry.
    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [AGE_W-1:0] age;
    } t_entry;

    // Write command into the entry memory.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr;

    // Update of the valid flags at the processed slot.
    typedef struct packed {
        logic set;
        logic clr;
    } t_vop;

endpackage

### rtl/core/arpc_table.sv
// ----------------------------------------------------------------------------
// ARP cache table
// Entry memory with registered synchronous read, plus per-slot valid flags.
// ----------------------------------------------------------------------------
module arpc_table
    import arpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data,
    input  t_wr              i_wr,
    input  logic [IDX_W-1:0] i_slot_idx,
    input  t_vop             i_vop,
    output logic             o_slot_valid
);

    t_entry                 mem [CACHE_SLOTS];
    logic [CACHE_SLOTS-1:0] r_valid;

    // Entry memory: registered read, single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

    // Valid flags are cleared at reset; only they decide whether an entry counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_vop.set) begin
            r_valid[i_slot_idx] <= 1'b1;
        end else if (i_vop.clr) begin
            r_valid[i_slot_idx] <= 1'b0;
        end
    end

    assign o_slot_valid = r_valid[i_slot_idx];

endmodule

### rtl/core/arp_cache_with_aging.sv
// ----------------------------------------------------------------------------
// ARP cache with aging
// IP-to-MAC cache with learn, lookup and tick-driven aging over a slot table.
// ----------------------------------------------------------------------------
// Usage:
// An input transaction carries a function code, an IP address and a MAC
// address. Learn stores the pair in the lowest free slot with age zero, or
// flags learn_dropped when the table is full. Lookup returns hit and the MAC
// of the matching valid slot with the greatest age (lower slot on a tie).
// Tick ages every valid slot and frees those at or above the age limit. Every
// input transaction yields exactly one output transaction.
// Each item walks the slot table through the entry memory, one slot per
// cycle. A lookup, a tick or a dropped learn walks every slot; a learn that
// takes a slot ends its walk there, and the unused code goes straight to
// the result. One item is in work at a time; the input stalls while a walk
// is in progress.
// The result sits in an output register, so the next item is accepted while
// it waits; a stalled receiver holds the result steady and a finished walk
// waits for the register to free up.
// Synchronous reset empties the table at once (valid flags only) and loads
// the age limit with 15. The user must write the age limit over its own
// channel only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module arp_cache_with_aging
    import arpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [IP_W-1:0]   i_ip_address,
    input  logic [MAC_W-1:0]  i_mac_address,
    // Output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_hit,
    output logic [MAC_W-1:0]  o_found_mac,
    output logic              o_learn_dropped,
    // Configuration channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [AGE_W-1:0]  i_cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CACHE_SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_SLOTS = CNT_W'(CACHE_SLOTS);

    // Control registers
    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_pval, n_pval;
    logic             r_out_valid, n_out_valid;
    logic [AGE_W-1:0] r_age_limit;

    // Payload registers
    logic [FUNC_W-1:0] r_func, n_func;
    logic [IP_W-1:0]   r_ip, n_ip;
    logic [MAC_W-1:0]  r_mac, n_mac;
    logic [IDX_W-1:0]  r_pidx, n_pidx;
    logic              r_have, n_have;
    logic [AGE_W-1:0]  r_best_age, n_best_age;
    logic [MAC_W-1:0]  r_best_mac, n_best_mac;
    logic              r_dropped, n_dropped;
    logic              r_out_hit, n_out_hit;
    logic [MAC_W-1:0]  r_out_mac, n_out_mac;
    logic              r_out_drop, n_out_drop;

    // Table interface
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_data;
    t_wr              wr;
    t_vop             vop;
    logic             slot_valid;

    logic in_accept;
    logic out_free;
    logic in_range;
    logic last;

    arpc_table u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_addr    (rd_addr),
        .o_rd_data    (rd_data),
        .i_wr         (wr),
        .i_slot_idx   (r_pidx),
        .i_vop        (vop),
        .o_slot_valid (slot_valid)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign in_range    = (r_cnt < CNT_SLOTS);
    assign last        = (r_pidx == LAST_IDX);

    // Sequencer: reads one slot per cycle and processes it in the next cycle.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pval      = r_pval;
        n_out_valid = r_out_valid;
        n_func      = r_func;
        n_ip        = r_ip;
        n_mac       = r_mac;
        n_pidx      = r_pidx;
        n_have      = r_have;
        n_best_age  = r_best_age;
        n_best_mac  = r_best_mac;
        n_dropped   = r_dropped;
        n_out_hit   = r_out_hit;
        n_out_mac   = r_out_mac;
        n_out_drop  = r_out_drop;
        rd_addr     = '0;
        wr          = '0;
        vop         = '0;

        // The receiver takes the pending result.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_func     = i_func;
                    n_ip       = i_ip_address;
                    n_mac      = i_mac_address;
                    n_cnt      = '0;
                    n_pval     = 1'b0;
                    n_have     = 1'b0;
                    n_best_age = '0;
                    n_best_mac = '0;
                    n_dropped  = 1'b0;
                    n_state    = (i_func == FUNC_UNUSED) ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue the read of the next slot.
                rd_addr = in_range ? r_cnt[IDX_W-1:0] : '0;
                n_pval  = in_range;
                n_pidx  = r_cnt[IDX_W-1:0];
                n_cnt   = in_range ? r_cnt + CNT_W'(1) : r_cnt;

                // Process the slot whose data has just arrived.
                if (r_pval) begin
                    case (r_func)
                        FUNC_LEARN: begin
                            if (!slot_valid) begin
                                wr.en       = 1'b1;
                                wr.addr     = r_pidx;
                                wr.data.ip  = r_ip;
                                wr.data.mac = r_mac;
                                wr.data.age = '0;
                                vop.set     = 1'b1;
                                n_state     = ST_RESULT;
                            end else if (last) begin
                                n_dropped = 1'b1;
                                n_state   = ST_RESULT;
                            end
                        end
                        FUNC_LOOKUP: begin
                            if (slot_valid && (rd_data.ip == r_ip) &&
                                (!r_have || (rd_data.age > r_best_age))) begin
                                n_have     = 1'b1;
                                n_best_age = rd_data.age;
                                n_best_mac = rd_data.mac;
                            end
                            if (last) begin
                                n_state = ST_RESULT;
                            end
                        end
                        FUNC_TICK: begin
                            if (slot_valid) begin
                                if (rd_data.age >= r_age_limit) begin
                                    vop.clr = 1'b1;
                                end else begin
                                    wr.en       = 1'b1;
                                    wr.addr     = r_pidx;
                                    wr.data.ip  = rd_data.ip;
                                    wr.data.mac = rd_data.mac;
                                    wr.data.age = rd_data.age + AGE_W'(1);
                                end
                            end
                            if (last) begin
                                n_state = ST_RESULT;
                            end
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_RESULT: begin
                // Hand the result to the output register once it is free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_have;
                    n_out_mac   = r_best_mac;
                    n_out_drop  = r_dropped;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_pval      <= 1'b0;
            r_out_valid <= 1'b0;
            r_age_limit <= AGE_LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pval      <= n_pval;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_age_limit <= i_cfg_data;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_ip       <= n_ip;
        r_mac      <= n_mac;
        r_pidx     <= n_pidx;
        r_have     <= n_have;
        r_best_age <= n_best_age;
        r_best_mac <= n_best_mac;
        r_dropped  <= n_dropped;
        r_out_hit  <= n_out_hit;
        r_out_mac  <= n_out_mac;
        r_out_drop <= n_out_drop;
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_found_mac     = r_out_mac;
    assign o_learn_dropped = r_out_drop;

endmodule

### rtl/core/arpc_checker.sv
// ----------------------------------------------------------------------------
// ARP cache port checker
// Concurrent assertions on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module arpc_checker
    import arpc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_hit,
    input logic [MAC_W-1:0]  o_found_mac,
    input logic              o_learn_dropped
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_hit) && $stable(o_found_mac) &&
            $stable(o_learn_dropped))
        else $error("stalled result changed");

    // A miss reports a zero hardware address.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_found_mac == '0)
        else $error("nonzero MAC on a miss");

    // A result is never both a lookup hit and a dropped learn.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_learn_dropped))
        else $error("hit and learn_dropped both set");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind arp_cache_with_aging arpc_checker u_arpc_checker (.*);

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP cache with aging testbench
// Drives learn, lookup, tick and unused-code transactions into the cache and
// checks every reply against a software copy of the slot table. Runs a
// directed opening and several random phases under different age limits,
// with sender idling, receiver stalling and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import arpc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 40;

    // One input transaction.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
    } t_arp_item;

    // One output transaction.
    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] mac;
        logic             dropped;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              o_in_stall;
    logic [FUNC_W-1:0] in_func = '0;
    logic [IP_W-1:0]   in_ip = '0;
    logic [MAC_W-1:0]  in_mac = '0;

    logic              o_out_valid;
    logic              out_stall = 1'b0;
    logic              o_hit;
    logic [MAC_W-1:0]  o_found_mac;
    logic              o_learn_dropped;

    logic              cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [AGE_W-1:0]  cfg_data = '0;

    // Stimulus and checking state.
    t_arp_item arp_items[$];
    t_reply    pending_replies[$];
    t_arp_item on_bus;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_requests = 0;
    int        hold_served = 0;
    int        hold_left = 0;
    int        n_err = 0;
    int        cycle_count = 0;
    logic [IP_W-1:0] ip_pool[12];

    // Software copy of the cache.
    logic             tab_valid[CACHE_SLOTS];
    logic [IP_W-1:0]  tab_ip[CACHE_SLOTS];
    logic [MAC_W-1:0] tab_mac[CACHE_SLOTS];
    logic [AGE_W-1:0] tab_age[CACHE_SLOTS];
    logic [AGE_W-1:0] age_limit;

    arp_cache_with_aging u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (in_func),
        .i_ip_address    (in_ip),
        .i_mac_address   (in_mac),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_hit           (o_hit),
        .o_found_mac     (o_found_mac),
        .o_learn_dropped (o_learn_dropped),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Applies one transaction to the table copy and returns the reply it earns.
    function automatic t_reply cache_answer(input t_arp_item it);
        t_reply           r;
        bit               placed;
        bit               have;
        logic [AGE_W-1:0] best_age;
        r = '0;
        placed = 1'b0;
        have = 1'b0;
        best_age = '0;
        case (it.func)
            FUNC_LEARN: begin
                for (int s = 0; s < CACHE_SLOTS; s++) begin
                    if (!placed && !tab_valid[s]) begin
                        tab_valid[s] = 1'b1;
                        tab_ip[s] = it.ip;
                        tab_mac[s] = it.mac;
                        tab_age[s] = '0;
                        placed = 1'b1;
                    end
                end
                r.dropped = !placed;
            end
            FUNC_LOOKUP: begin
                // The oldest matching slot wins; the lower slot wins a tie.
                for (int s = 0; s < CACHE_SLOTS; s++) begin
                    if (tab_valid[s] && tab_ip[s] == it.ip) begin
                        if (!have || tab_age[s] > best_age) begin
                            have = 1'b1;
                            best_age = tab_age[s];
                            r.mac = tab_mac[s];
                        end
                    end
                end
                r.hit = have;
            end
            FUNC_TICK: begin
                // A slot is freed on the tick that would take it past the limit.
                for (int s = 0; s < CACHE_SLOTS; s++) begin
                    if (tab_valid[s]) begin
                        if (tab_age[s] >= age_limit) begin
                            tab_valid[s] = 1'b0;
                        end else begin
                            tab_age[s] = tab_age[s] + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic push_item(input logic [FUNC_W-1:0] f, input logic [IP_W-1:0] ip,
                             input logic [MAC_W-1:0] mac);
        t_arp_item it;
        it.func = f;
        it.ip = ip;
        it.mac = mac;
        arp_items.push_back(it);
    endtask

    // Random traffic over a small address pool so that lookups hit and
    // duplicates form; a few addresses are fully random.
    task automatic add_random(input int count);
        int                p;
        logic [FUNC_W-1:0] f;
        logic [IP_W-1:0]   ip;
        for (int k = 0; k < 12; k++) begin
            ip_pool[k] = $urandom;
        end
        for (int n = 0; n < count; n++) begin
            p = $urandom_range(99);
            if (p < 35) begin
                f = FUNC_LEARN;
            end else if (p < 75) begin
                f = FUNC_LOOKUP;
            end else if (p < 95) begin
                f = FUNC_TICK;
            end else begin
                f = FUNC_UNUSED;
            end
            if ($urandom_range(9) == 0) begin
                ip = $urandom;
            end else begin
                ip = ip_pool[$urandom_range(11)];
            end
            push_item(f, ip, rand_mac());
        end
    endtask

    // Waits until every transaction has been sent and answered.
    task automatic drain();
        do @(negedge i_clk);
        while (arp_items.size() != 0 || in_valid || pending_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_age_limit(input logic [AGE_W-1:0] v);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        age_limit = v;
        @(negedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Sequence of phases.
    initial begin
        for (int s = 0; s < CACHE_SLOTS; s++) begin
            tab_valid[s] = 1'b0;
            tab_ip[s] = '0;
            tab_mac[s] = '0;
            tab_age[s] = '0;
        end
        age_limit = AGE_LIMIT_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening: extremes, duplicates, ties, unused code, full table.
        set_idling(0, 0);
        push_item(FUNC_LOOKUP, 32'h0000_0000, '0);
        push_item(FUNC_LEARN, 32'h0000_0000, 48'h0);
        push_item(FUNC_LEARN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        push_item(FUNC_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        push_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0);
        push_item(FUNC_TICK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        push_item(FUNC_LEARN, 32'h0A00_0001, 48'h1111_2222_3333);
        push_item(FUNC_LEARN, 32'hFFFF_FFFF, 48'hAAAA_5555_AAAA);
        push_item(FUNC_LOOKUP, 32'hFFFF_FFFF, '0);
        push_item(FUNC_LEARN, 32'h0A00_0001, 48'h4444_5555_6666);
        push_item(FUNC_LOOKUP, 32'h0A00_0001, '0);
        push_item(FUNC_UNUSED, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF);
        for (int n = 0; n < 11; n++) begin
            push_item(FUNC_LEARN, $urandom, rand_mac());
        end
        push_item(FUNC_LEARN, 32'h5555_AAAA, 48'h5555_AAAA_5555);
        push_item(FUNC_LOOKUP, 32'h5555_AAAA, '0);
        drain();

        // Random phases under different limits and idling.
        set_age_limit(8'd0);
        add_random(200);
        drain();

        set_age_limit(8'd255);
        set_idling(81, 0);
        add_random(250);
        drain();

        set_age_limit(8'd3);
        set_idling(0, 81);
        add_random(250);
        drain();

        set_age_limit(8'($urandom_range(1, 30)));
        set_idling(19, 19);
        add_random(250);
        drain();

        // Long receiver hold-off while the sender keeps offering.
        set_age_limit(AGE_LIMIT_RESET);
        set_idling(0, 0);
        add_random(150);
        hold_requests = hold_requests + 1;
        drain();

        set_age_limit(8'($urandom_range(255)));
        set_idling(81, 81);
        add_random(250);
        drain();

        if (n_err == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Driver: offers queued transactions and predicts each accepted one.
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                pending_replies.push_back(cache_answer(on_bus));
            end
            if (!in_valid || !o_in_stall) begin
                if (arp_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = arp_items.pop_front();
                    in_func <= on_bus.func;
                    in_ip <= on_bus.ip;
                    in_mac <= on_bus.mac;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted in cycles.
    always @(posedge i_clk) begin : hold_off
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    // Monitor: checks each accepted reply and drives the receiver stall.
    always @(posedge i_clk) begin : monitor
        t_reply want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: reply with none expected: hit %0b mac %h dropped %0b",
                             $time, o_hit, o_found_mac, o_learn_dropped);
                    n_err = n_err + 1;
                end else begin
                    want = pending_replies.pop_front();
                    if (o_hit !== want.hit) begin
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, o_hit);
                        n_err = n_err + 1;
                    end
                    if (o_found_mac !== want.mac) begin
                        $display("%0t: found_mac expected %h actual %h",
                                 $time, want.mac, o_found_mac);
                        n_err = n_err + 1;
                    end
                    if (o_learn_dropped !== want.dropped) begin
                        $display("%0t: learn_dropped expected %0b actual %0b",
                                 $time, want.dropped, o_learn_dropped);
                        n_err = n_err + 1;
                    end
                end
            end
            if (hold_left != 0) begin
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

endmodule
